// ----- hdl/stpe_pkg.sv -----
// Shared types and constants of the serpentine toolpath point emitter.
`default_nettype none

package stpe_pkg;

    localparam int MAX_GRID_DEF    = 256;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_HEIGHT = 2'd3;

    localparam logic [8:0]  GRID_SIZE_RST   = 9'd250;
    localparam logic [8:0]  ROW_STRIDE_RST  = 9'd16;
    localparam logic [15:0] MIN_HEIGHT_RST  = 16'd0;
    localparam logic [15:0] SAFE_HEIGHT_RST = 16'd26419;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // result slots of one item, in emission order
    localparam int NSLOT       = 5;
    localparam int SLOT_CUT_A  = 0;
    localparam int SLOT_CUT_B  = 1;
    localparam int SLOT_END    = 2;
    localparam int SLOT_LIFT   = 3;
    localparam int SLOT_RETURN = 4;

    typedef enum logic [1:0] {
        MOVE_CUT    = 2'd0,
        MOVE_LIFT   = 2'd1,
        MOVE_RETURN = 2'd2
    } move_kind_t;

    typedef struct packed {
        logic [NSLOT-1:0] mask;
        logic [7:0]       pcol;
        logic [7:0]       ecol;
        logic [7:0]       row;
        logic [15:0]      pheight;
        logic [15:0]      eheight;
    } desc_t;

endpackage

`default_nettype wire

// ----- hdl/stpe_front.sv -----
// Front end: clamps samples, tracks the walk position and classifies the results of each item.
`default_nettype none

module stpe_front #(
    parameter int MAX_GRID    = stpe_pkg::MAX_GRID_DEF,
    parameter int HEIGHT_BITS = stpe_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [HEIGHT_BITS-1:0] sample_height,
    input  wire logic [8:0]             grid_size,
    input  wire logic [8:0]             row_stride,
    input  wire logic [15:0]            min_height,
    input  wire logic                   q_full,
    output logic                        q_push,
    output stpe_pkg::desc_t             q_desc
);

    localparam int CW  = $clog2(MAX_GRID);
    localparam int GW0 = $clog2(MAX_GRID + 1);
    localparam int PW  = ((GW0 > 9) ? GW0 : 9) + 1;
    localparam int HVW = (HEIGHT_BITS > 16) ? HEIGHT_BITS : 16;

    logic [CW-1:0]  col_count_reg, col_count_next;
    logic [CW-1:0]  row_index_reg, row_index_next;
    logic           reverse_row_reg, reverse_row_next;
    logic [HVW-1:0] pending_height_reg, pending_height_next;
    logic           pending_valid_reg, pending_valid_next;
    logic [HVW-1:0] previous_height_reg, previous_height_next;

    logic [PW-1:0]  grid_w, max_w, g, gm1, s, col_w, px, pcol, ccol, row_sum;
    logic [HVW-1:0] raw_w, min_w, h;
    logic           accept, at_edge, inner_diff, prev_diff, last, pass_end;

    always_comb
    begin
        grid_w = PW'(grid_size);
        max_w  = PW'(MAX_GRID);
        if (grid_w < PW'(2))
        begin
            g = PW'(2);
        end
        else if (grid_w > max_w)
        begin
            g = max_w;
        end
        else
        begin
            g = grid_w;
        end
        gm1 = g - PW'(1);
        s   = (row_stride == 9'd0) ? PW'(1) : PW'(row_stride);

        raw_w = HVW'(sample_height);
        min_w = HVW'(min_height);
        h     = (raw_w > min_w) ? raw_w : min_w;

        col_w = PW'(col_count_reg);
        px    = (col_count_reg == '0) ? '0 : col_w - PW'(1);
        pcol  = reverse_row_reg ? (gm1 - px) : px;
        ccol  = reverse_row_reg ? '0 : gm1;

        at_edge    = (px == '0) || (px == gm1);
        inner_diff = (px != '0) && (px < gm1) && (h != pending_height_reg);
        prev_diff  = (pending_height_reg != previous_height_reg) || at_edge;

        last     = (col_w >= gm1);
        row_sum  = PW'(row_index_reg) + s;
        pass_end = last && (row_sum >= g);
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        q_desc = '0;
        q_desc.mask[stpe_pkg::SLOT_CUT_A]  = pending_valid_reg && inner_diff;
        q_desc.mask[stpe_pkg::SLOT_CUT_B]  = pending_valid_reg && prev_diff;
        q_desc.mask[stpe_pkg::SLOT_END]    = last;
        q_desc.mask[stpe_pkg::SLOT_LIFT]   = pass_end;
        q_desc.mask[stpe_pkg::SLOT_RETURN] = pass_end;
        q_desc.pcol    = pcol[7:0];
        q_desc.ecol    = ccol[7:0];
        q_desc.row     = 8'(row_index_reg);
        q_desc.pheight = pending_height_reg[15:0];
        q_desc.eheight = h[15:0];
    end

    assign q_push = accept && (q_desc.mask != '0);

    always_comb
    begin
        col_count_next       = col_count_reg;
        row_index_next       = row_index_reg;
        reverse_row_next     = reverse_row_reg;
        pending_height_next  = pending_height_reg;
        pending_valid_next   = pending_valid_reg;
        previous_height_next = previous_height_reg;
        if (accept)
        begin
            if (pending_valid_reg)
            begin
                previous_height_next = pending_height_reg;
                pending_valid_next   = 1'b0;
            end
            if (last)
            begin
                previous_height_next = h;
                col_count_next       = '0;
                if (pass_end)
                begin
                    row_index_next   = '0;
                    reverse_row_next = 1'b0;
                end
                else
                begin
                    row_index_next   = row_sum[CW-1:0];
                    reverse_row_next = !reverse_row_reg;
                end
            end
            else
            begin
                pending_height_next = h;
                pending_valid_next  = 1'b1;
                col_count_next      = col_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg       <= '0;
            row_index_reg       <= '0;
            reverse_row_reg     <= 1'b0;
            pending_height_reg  <= '0;
            pending_valid_reg   <= 1'b0;
            previous_height_reg <= '0;
        end
        else
        begin
            col_count_reg       <= col_count_next;
            row_index_reg       <= row_index_next;
            reverse_row_reg     <= reverse_row_next;
            pending_height_reg  <= pending_height_next;
            pending_valid_reg   <= pending_valid_next;
            previous_height_reg <= previous_height_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stpe_queue.sv -----
// Short descriptor queue between the front end and the back end.
`default_nettype none

module stpe_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire stpe_pkg::desc_t push_desc,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output stpe_pkg::desc_t      head_desc
);

    stpe_pkg::desc_t                  entry_reg [stpe_pkg::QDEPTH];
    logic [stpe_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [stpe_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [stpe_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign full       = (count_reg == stpe_pkg::QCNT_W'(stpe_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + stpe_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + stpe_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + stpe_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - stpe_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stpe_back.sv -----
// Back end: walks the result slots of each queued item into the output register.
`default_nettype none

module stpe_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire stpe_pkg::desc_t head_desc,
    output logic                 pop,
    input  wire logic [15:0]     safe_height,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [1:0]           move_kind,
    output logic [7:0]           column,
    output logic [7:0]           row,
    output logic [15:0]          point_height,
    output logic                 last_of_run
);

    logic [stpe_pkg::NSLOT-1:0] consumed_reg, consumed_next;
    logic                       out_valid_reg;
    stpe_pkg::move_kind_t       kind_reg;
    logic [7:0]                 column_reg, row_reg;
    logic [15:0]                height_reg;
    logic                       last_reg;

    logic [stpe_pkg::NSLOT-1:0] remaining, sel;
    logic                       load, sel_last;
    stpe_pkg::move_kind_t       sel_kind;
    logic [7:0]                 sel_col, sel_row;
    logic [15:0]                sel_height;

    assign remaining = head_desc.mask & ~consumed_reg;
    assign sel       = remaining & (~remaining + stpe_pkg::NSLOT'(1));
    assign sel_last  = ((remaining & ~sel) == '0);
    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && sel_last;

    always_comb
    begin
        sel_kind   = stpe_pkg::MOVE_CUT;
        sel_col    = head_desc.pcol;
        sel_row    = head_desc.row;
        sel_height = head_desc.pheight;
        case (sel)
            5'b00001, 5'b00010:
            begin
                sel_kind = stpe_pkg::MOVE_CUT;
            end
            5'b00100:
            begin
                sel_col    = head_desc.ecol;
                sel_height = head_desc.eheight;
            end
            5'b01000:
            begin
                sel_kind   = stpe_pkg::MOVE_LIFT;
                sel_col    = head_desc.ecol;
                sel_height = safe_height;
            end
            5'b10000:
            begin
                sel_kind   = stpe_pkg::MOVE_RETURN;
                sel_col    = 8'd0;
                sel_row    = 8'd0;
                sel_height = safe_height;
            end
            default:
            begin
                sel_kind = stpe_pkg::MOVE_CUT;
            end
        endcase
    end

    always_comb
    begin
        consumed_next = consumed_reg;
        if (load)
        begin
            consumed_next = sel_last ? '0 : (consumed_reg | sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            consumed_reg <= consumed_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= sel_kind;
            column_reg <= sel_col;
            row_reg    <= sel_row;
            height_reg <= sel_height;
            last_reg   <= sel_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign move_kind    = kind_reg;
    assign column       = column_reg;
    assign row          = row_reg;
    assign point_height = height_reg;
    assign last_of_run  = last_reg;

    // a queued item always has a slot left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (remaining != '0))
        else $error("queued item with no result left");

    // return to origin closes the item at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == stpe_pkg::MOVE_RETURN))
            |-> (last_reg && (column_reg == 8'd0) && (row_reg == 8'd0)))
        else $error("return move not last or not at origin");

    // a lift is always followed by the return of the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (sel_kind == stpe_pkg::MOVE_LIFT)) |-> !sel_last)
        else $error("lift sent as last result");

endmodule

`default_nettype wire

// ----- hdl/serpentine_toolpath_point_emitter.sv -----
// Top level of the serpentine toolpath point emitter: config registers, front end, queue, back end.
//
// Input channel: sample_height with in_valid/in_stall, one heightmap sample per item in
// serpentine walk order. Output channel: move_kind, column, row, point_height and
// last_of_run with out_valid/out_stall, up to five moves per item. Config port: cfg_write,
// cfg_index and cfg_data write grid_size, row_stride, min_height, safe_height.
// A sample is taken while in_stall is low; its results are queued (four items deep) and
// leave the output register one per cycle while out_stall is low, the first one
// passing through a queue entry and then the output register. A sample with at most
// one result sustains one sample per cycle unless the output stalls; the output rate
// of one move per cycle sets the pace otherwise (up to five moves at the end of a pass).
// Reset clears the walk position and loads the default register values; no
// clearing pass is needed. When the receiver stalls, the output holds, the queue
// fills, and in_stall rises once the queue is full.
`default_nettype none

module serpentine_toolpath_point_emitter #(
    parameter int MAX_GRID    = stpe_pkg::MAX_GRID_DEF,
    parameter int HEIGHT_BITS = stpe_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [stpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stpe_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [HEIGHT_BITS-1:0]         sample_height,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          move_kind,
    output logic [7:0]                          column,
    output logic [7:0]                          row,
    output logic [15:0]                         point_height,
    output logic                                last_of_run
);

    logic [8:0]  grid_size_reg, row_stride_reg;
    logic [15:0] min_height_reg, safe_height_reg;

    logic            q_push, q_full, q_pop, q_head_valid;
    stpe_pkg::desc_t q_desc, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= stpe_pkg::GRID_SIZE_RST;
            row_stride_reg  <= stpe_pkg::ROW_STRIDE_RST;
            min_height_reg  <= stpe_pkg::MIN_HEIGHT_RST;
            safe_height_reg <= stpe_pkg::SAFE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                stpe_pkg::REG_GRID_SIZE:   grid_size_reg   <= cfg_data[8:0];
                stpe_pkg::REG_ROW_STRIDE:  row_stride_reg  <= cfg_data[8:0];
                stpe_pkg::REG_MIN_HEIGHT:  min_height_reg  <= cfg_data;
                stpe_pkg::REG_SAFE_HEIGHT: safe_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    stpe_front #(
        .MAX_GRID    (MAX_GRID),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_height (sample_height),
        .grid_size     (grid_size_reg),
        .row_stride    (row_stride_reg),
        .min_height    (min_height_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (q_desc)
    );

    stpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_desc  (q_head)
    );

    stpe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_desc    (q_head),
        .pop          (q_pop),
        .safe_height  (safe_height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .move_kind    (move_kind),
        .column       (column),
        .row          (row),
        .point_height (point_height),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
